// File: src/pal_pkg.sv
// ---------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Request and response payloads, command and status codes, cell controls.
// ---------------------------------------------------------------------------
package pal_pkg;

  localparam int DefCapacity = 16;
  localparam int DataW       = 32;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_REPLACE = 3'd3;
  localparam logic [2:0] CMD_INSERT  = 3'd4;
  localparam logic [2:0] CMD_REMOVE  = 3'd5;
  localparam logic [2:0] CMD_REVERSE = 3'd6;
  localparam logic [2:0] CMD_DUMP    = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_LEFT  = 2'd2;
  localparam logic [1:0] CELL_RIGHT = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [7:0]              position;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] data_out;
    logic [6:0]              item_count;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

endpackage

// File: src/pal_cell.sv
// ---------------------------------------------------------------------------
// pal_cell: one storage cell of the list
// Holds one word; loads a new word or takes a neighbor's word.
// ---------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [DataW-1:0] left,
  input  logic signed [DataW-1:0] right,
  output logic signed [DataW-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_LOAD:  q <= ctl.value;
      CELL_LEFT:  q <= left;
      CELL_RIGHT: q <= right;
      default:    q <= q;
    endcase
  end

endmodule

// File: src/positional_array_list.sv
// ---------------------------------------------------------------------------
// positional_array_list: ordered list of signed words in a row of cells
// Usage:
//   Requests arrive on req (cmd, position, value) with req_valid/req_stall;
//   responses leave on rsp (status, data_out, item_count, last) with
//   rsp_valid/rsp_stall. A request is taken when valid is high and stall low.
//   Every command except dump gives one response, registered in the cycle
//   after it is taken; one command per cycle is sustained while the
//   receiver keeps up and no dump is running. Insert and remove shift the
//   cells from the affected position on toward their neighbors; reverse only
//   flips the orientation flag that maps positions to cells. Dump gives one
//   response per entry, one per cycle while rsp_stall is low, last on the
//   final one; req_stall stays high until the last entry is registered in rsp.
//   Reset empties the list and drops any pending response; no clearing pass
//   is run, since cells beyond the entry count are never read.
//   While a pending response sees rsp_stall high, it holds and req_stall is
//   raised.
// ---------------------------------------------------------------------------
module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_INS  = 2'd1;
  localparam logic [1:0] M_REP  = 2'd2;
  localparam logic [1:0] M_REM  = 2'd3;

  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;
  logic          dumping;
  logic [CW-1:0] dump_idx;

  logic signed [DataW-1:0] cell_q [CAPACITY];
  cell_ctl_t               cell_ctl [CAPACITY];

  logic       accept, rsp_free, is_empty, is_full;
  logic [7:0] cnt8, pm1, phys8, ins8, rd_log8, rd_phys8;
  logic [1:0] mode, status_c;
  logic       last_c, dump_start;
  logic signed [DataW-1:0] rd_data, data_c;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = dumping || !rsp_free;
  assign accept    = req_valid && !req_stall;

  assign cnt8     = 8'(count);
  assign pm1      = req.position - 8'd1;
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(CAPACITY));
  assign phys8    = rev ? (cnt8 - 8'd1 - pm1) : pm1;

  assign rd_log8  = dumping ? 8'(dump_idx) : ((req.cmd == CMD_DUMP) ? 8'd0 : pm1);
  assign rd_phys8 = rev ? (cnt8 - 8'd1 - rd_log8) : rd_log8;
  assign rd_data  = cell_q[rd_phys8[IW-1:0]];

  always_comb begin
    status_c   = ST_OK;
    data_c     = '0;
    count_next = count;
    rev_next   = rev;
    mode       = M_NONE;
    ins8       = '0;
    last_c     = 1'b1;
    dump_start = 1'b0;
    unique case (req.cmd) inside
      CMD_CLEAR: begin
        count_next = '0;
        rev_next   = 1'b0;
      end
      CMD_APPEND: begin
        if (is_full) begin
          status_c = ST_OVER;
        end else begin
          mode       = M_INS;
          ins8       = rev ? 8'd0 : cnt8;
          count_next = count + CW'(1);
        end
      end
      CMD_READ, CMD_REPLACE, CMD_REMOVE: begin
        if (is_empty) begin
          status_c = ST_UNDER;
        end else if (req.position == 8'd0 || req.position > cnt8) begin
          status_c = ST_RANGE;
        end else if (req.cmd == CMD_READ) begin
          data_c = rd_data;
        end else if (req.cmd == CMD_REPLACE) begin
          mode = M_REP;
        end else begin
          mode       = M_REM;
          count_next = count - CW'(1);
        end
      end
      CMD_INSERT: begin
        if (is_full) begin
          status_c = ST_OVER;
        end else if (req.position == 8'd0 || req.position > cnt8 + 8'd1) begin
          status_c = ST_RANGE;
        end else begin
          mode       = M_INS;
          ins8       = rev ? (cnt8 - pm1) : pm1;
          count_next = count + CW'(1);
        end
      end
      CMD_REVERSE: begin
        if (is_empty) begin
          status_c = ST_UNDER;
        end else begin
          rev_next = ~rev;
        end
      end
      default: begin
        if (is_empty) begin
          status_c = ST_UNDER;
        end else begin
          data_c     = rd_data;
          last_c     = (count == CW'(1));
          dump_start = (count != CW'(1));
        end
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].value = req.value;
      cell_ctl[i].op    = CELL_HOLD;
      if (accept) begin
        case (mode)
          M_INS: begin
            if (8'(i) == ins8) begin
              cell_ctl[i].op = CELL_LOAD;
            end else if (8'(i) > ins8) begin
              cell_ctl[i].op = CELL_LEFT;
            end
          end
          M_REP: begin
            if (8'(i) == phys8) begin
              cell_ctl[i].op = CELL_LOAD;
            end
          end
          M_REM: begin
            if (8'(i) >= phys8 && i < CAPACITY - 1) begin
              cell_ctl[i].op = CELL_RIGHT;
            end
          end
          default: cell_ctl[i].op = CELL_HOLD;
        endcase
      end
    end

    pal_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .left  (cell_q[(i > 0) ? i - 1 : i]),
      .right (cell_q[(i < CAPACITY - 1) ? i + 1 : i]),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rev       <= 1'b0;
      dumping   <= 1'b0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      count          <= count_next;
      rev            <= rev_next;
      dumping        <= dump_start;
      dump_idx       <= CW'(1);
      rsp_valid      <= 1'b1;
      rsp.status     <= status_c;
      rsp.data_out   <= data_c;
      rsp.item_count <= 7'(count_next);
      rsp.last       <= last_c;
    end else if (dumping && rsp_free) begin
      dump_idx       <= dump_idx + CW'(1);
      dumping        <= (dump_idx != count - CW'(1));
      rsp_valid      <= 1'b1;
      rsp.status     <= ST_OK;
      rsp.data_out   <= rd_data;
      rsp.item_count <= 7'(count);
      rsp.last       <= (dump_idx == count - CW'(1));
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: tb/positional_array_list_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_array_list_tb: self-checking bench for the positional array list
// A short table of directed requests covers the empty and range cases
// and every command. It is followed by random request sequences that grow,
// work on and shrink the list. A shadow copy of the list computes the
// responses due for every accepted request, and each accepted response is
// compared field by field. Requests idle and responses stall at random.
// ---------------------------------------------------------------------------
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int CAPACITY   = DefCapacity;
  localparam int RAND_REQS  = 198;
  localparam int DRAIN      = 20;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    req_t r;
    bit   pinned;
    rsp_t pin;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic signed [DataW-1:0] list_words [CAPACITY];
  int   list_count = 0;
  rsp_t due_rsps [$];
  rsp_t want_rsp;

  int errors      = 0;
  int n_reqs      = 0;
  int n_rsps      = 0;
  int n_dumps     = 0;
  int peak_count  = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_span  = 0;
  int cycle_count = 0;

  positional_array_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic list_apply(input req_t r);
    rsp_t o;
    int p;
    int i;
    logic signed [DataW-1:0] t;
    o = '0;
    o.status = ST_OK;
    o.last = 1'b1;
    p = r.position;
    case (r.cmd)
      CMD_CLEAR: list_count = 0;
      CMD_APPEND: begin
        if (list_count >= CAPACITY) begin
          o.status = ST_OVER;
        end else begin
          list_words[list_count] = r.value;
          list_count++;
        end
      end
      CMD_READ, CMD_REPLACE, CMD_REMOVE: begin
        if (list_count == 0) begin
          o.status = ST_UNDER;
        end else if (p < 1 || p > list_count) begin
          o.status = ST_RANGE;
        end else if (r.cmd == CMD_READ) begin
          o.data_out = list_words[p-1];
        end else if (r.cmd == CMD_REPLACE) begin
          list_words[p-1] = r.value;
        end else begin
          for (i = p - 1; i < list_count - 1; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      CMD_INSERT: begin
        if (list_count >= CAPACITY) begin
          o.status = ST_OVER;
        end else if (p < 1 || p > list_count + 1) begin
          o.status = ST_RANGE;
        end else begin
          for (i = list_count; i > p - 1; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = r.value;
          list_count++;
        end
      end
      CMD_REVERSE: begin
        if (list_count == 0) begin
          o.status = ST_UNDER;
        end else begin
          for (i = 0; i < list_count / 2; i++) begin
            t = list_words[i];
            list_words[i] = list_words[list_count-1-i];
            list_words[list_count-1-i] = t;
          end
        end
      end
      CMD_DUMP: begin
        n_dumps++;
        if (list_count != 0) begin
          for (i = 0; i < list_count; i++) begin
            o.data_out = list_words[i];
            o.item_count = 7'(list_count);
            o.last = (i == list_count - 1);
            due_rsps.push_back(o);
          end
          return;
        end
        o.status = ST_UNDER;
      end
    endcase
    if (list_count > peak_count) peak_count = list_count;
    o.item_count = 7'(list_count);
    due_rsps.push_back(o);
  endtask

  task automatic send_req(input req_t r);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    list_apply(r);
    n_reqs++;
  endtask

  function automatic dir_row_t mk_row(logic [2:0] c, logic [7:0] p, logic signed [DataW-1:0] v,
                                      bit pin = 1'b0, logic [1:0] s = ST_OK,
                                      logic signed [DataW-1:0] d = '0, logic [6:0] n = '0);
    dir_row_t row;
    row.r.cmd = c;
    row.r.position = p;
    row.r.value = v;
    row.pinned = pin;
    row.pin.status = s;
    row.pin.data_out = d;
    row.pin.item_count = n;
    row.pin.last = 1'b1;
    return row;
  endfunction

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(8, 60);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= (stall_span[1:0] == 2'd0);
      default: rsp_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsps++;
      if (due_rsps.size() == 0) begin
        $error("response with none due: status %0d data_out %0d item_count %0d last %0d",
               rsp.status, rsp.data_out, rsp.item_count, rsp.last);
        errors++;
      end else begin
        want_rsp = due_rsps.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $error("status: expected %0d, actual %0d", want_rsp.status, rsp.status);
          errors++;
        end
        if (rsp.data_out !== want_rsp.data_out) begin
          $error("data_out: expected %0d, actual %0d", want_rsp.data_out, rsp.data_out);
          errors++;
        end
        if (rsp.item_count !== want_rsp.item_count) begin
          $error("item_count: expected %0d, actual %0d", want_rsp.item_count, rsp.item_count);
          errors++;
        end
        if (rsp.last !== want_rsp.last) begin
          $error("last: expected %0d, actual %0d", want_rsp.last, rsp.last);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses still due", cycle_count, due_rsps.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    req_t r;
    int k;
    int hi;
    int pick;
    bit grow;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(mk_row(CMD_READ,    8'd1,   32'sd7,  1, ST_UNDER, 0, 0));
    rows.push_back(mk_row(CMD_REMOVE,  8'd1,   32'sd0,  1, ST_UNDER, 0, 0));
    rows.push_back(mk_row(CMD_REPLACE, 8'd1,   32'sd9,  1, ST_UNDER, 0, 0));
    rows.push_back(mk_row(CMD_REVERSE, 8'd0,   32'sd0,  1, ST_UNDER, 0, 0));
    rows.push_back(mk_row(CMD_DUMP,    8'd0,   32'sd0,  1, ST_UNDER, 0, 0));
    rows.push_back(mk_row(CMD_INSERT,  8'd0,   32'sd3,  1, ST_RANGE, 0, 0));
    rows.push_back(mk_row(CMD_INSERT,  8'd2,   32'sd3,  1, ST_RANGE, 0, 0));
    rows.push_back(mk_row(CMD_INSERT,  8'd1,   32'sh8000_0000, 1, ST_OK, 0, 1));
    rows.push_back(mk_row(CMD_APPEND,  8'd255, 32'sh7FFF_FFFF, 1, ST_OK, 0, 2));
    rows.push_back(mk_row(CMD_READ,    8'd0,   32'sd0,  1, ST_RANGE, 0, 2));
    rows.push_back(mk_row(CMD_READ,    8'd3,   32'sd0,  1, ST_RANGE, 0, 2));
    rows.push_back(mk_row(CMD_READ,    8'd255, 32'sd0,  1, ST_RANGE, 0, 2));
    rows.push_back(mk_row(CMD_READ,    8'd1,   32'sd0,  1, ST_OK, 32'sh8000_0000, 2));
    rows.push_back(mk_row(CMD_REPLACE, 8'd2,   -32'sd1));
    rows.push_back(mk_row(CMD_INSERT,  8'd3,   32'sd0));
    rows.push_back(mk_row(CMD_INSERT,  8'd1,   32'sd5));
    rows.push_back(mk_row(CMD_REMOVE,  8'd4,   32'sd0));
    rows.push_back(mk_row(CMD_REMOVE,  8'd0,   32'sd0));
    rows.push_back(mk_row(CMD_REVERSE, 8'd0,   32'sd0));
    rows.push_back(mk_row(CMD_DUMP,    8'd0,   32'sd0));
    rows.push_back(mk_row(CMD_CLEAR,   8'd0,   32'sd0,  1, ST_OK, 0, 0));
    rows.push_back(mk_row(CMD_DUMP,    8'd0,   32'sd0,  1, ST_UNDER, 0, 0));

    foreach (rows[i]) begin
      send_req(rows[i].r);
      if (rows[i].pinned) due_rsps[due_rsps.size()-1] = rows[i].pin;
    end

    grow = 1'b1;
    for (k = 0; k < RAND_REQS; k++) begin
      if (list_count == 0) grow = 1'b1;
      else if (list_count == CAPACITY && $urandom_range(0, 2) == 0) grow = 1'b0;
      r.value = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: r.value = 32'sh8000_0000;
          1: r.value = 32'sh7FFF_FFFF;
          2: r.value = '0;
          default: r.value = -32'sd1;
        endcase
      end
      if ($urandom_range(0, 99) < 12) begin
        // noise: anything the fields allow
        r.cmd = 3'($urandom_range(0, 7));
        r.position = 8'($urandom_range(0, 255));
      end else begin
        pick = $urandom_range(0, 99);
        if (grow) begin
          r.cmd = (pick < 30) ? CMD_APPEND  : (pick < 55) ? CMD_INSERT  :
                  (pick < 65) ? CMD_READ    : (pick < 73) ? CMD_REPLACE :
                  (pick < 78) ? CMD_REMOVE  : (pick < 85) ? CMD_REVERSE :
                  (pick < 97) ? CMD_DUMP    : CMD_CLEAR;
        end else begin
          r.cmd = (pick < 35) ? CMD_REMOVE  : (pick < 50) ? CMD_READ    :
                  (pick < 62) ? CMD_REPLACE : (pick < 70) ? CMD_REVERSE :
                  (pick < 80) ? CMD_DUMP    : (pick < 90) ? CMD_APPEND  :
                  (pick < 97) ? CMD_INSERT  : CMD_CLEAR;
        end
        hi = (r.cmd == CMD_INSERT) ? list_count + 1 : list_count;
        if (hi < 1) hi = 1;
        if ($urandom_range(0, 99) < 85) begin
          r.position = 8'($urandom_range(1, hi));
        end else begin
          case ($urandom_range(0, 3))
            0: r.position = 8'd0;
            1: r.position = 8'(hi + 1);
            2: r.position = 8'd255;
            default: r.position = 8'($urandom_range(0, 255));
          endcase
        end
      end
      send_req(r);
    end

    req_valid <= 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (due_rsps.size() != 0) begin
      $error("%0d responses never arrived", due_rsps.size());
      errors++;
    end
    $display("%0d requests (%0d dumps) and %0d responses checked, list filled to %0d of %0d",
             n_reqs, n_dumps, n_rsps, peak_count, CAPACITY);
    $display("%0d mismatches over %0d cycles", errors, cycle_count);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
